// File: sv/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

  typedef struct packed {
    logic        command;
    logic [12:0] req_size;
    logic [11:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_addr;
    logic [12:0] granted_size;
    logic [7:0]  live_blocks;
    logic [12:0] free_bytes;
  } rsp_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

endpackage

// File: sv/ffha_ram.sv
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// Items that walk the segment memory take longest: first-fit scan, removal, ordered
// insertion and the free-byte sum. A zero-size allocate and a free rejected on its header
// skip these walks.
// Throughput: one item at a time; the next item is accepted after the result is taken.
// Reset: asynchronous, active low. A clearing pass then sweeps all HEAP_BYTES/ALIGN_BYTES
// entries of the header memory; no item is accepted until it is done.
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES      = 4096,
  parameter int ALIGN_BYTES     = 4,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_BLOCK_BYTES = 16,
  parameter int MAX_SEGMENTS    = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffha_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ffha_pkg::rsp_t out_data_o
);

  localparam int HeapAligned = (HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int HdrDepth    = HEAP_BYTES / ALIGN_BYTES;
  localparam int AW          = $clog2(HEAP_BYTES + 1) + 1;
  localparam int HW          = $clog2(HdrDepth);
  localparam int SW          = $clog2(MAX_SEGMENTS);
  localparam int CW          = $clog2(MAX_SEGMENTS + 1);
  localparam int AlShift     = $clog2(ALIGN_BYTES);
  localparam int SegW        = 2 * AW;
  localparam int HdrW        = AW + 1;
  localparam logic [AW-1:0] Hdr   = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] Split = AW'(HEADER_BYTES + MIN_BLOCK_BYTES);
  localparam logic [AW-1:0] Init  = AW'(HeapAligned - HEADER_BYTES);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_AHDR = 4'd2, S_ARD = 4'd3,
                         S_ACHK = 4'd4, S_FSCAN = 4'd5, S_FCHK = 4'd6, S_DEL = 4'd7,
                         S_INS = 4'd8, S_HW = 4'd9, S_SUM = 4'd10, S_OUT = 4'd11,
                         S_FHDR = 4'd12, S_FHI = 4'd13;

  logic [3:0] state_q, state_d;
  logic [HW-1:0] clr_q, clr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [7:0] live_q, live_d;
  logic [12:0] ftot_q, ftot_d;
  logic cmd_q, cmd_d;
  logic [AW-1:0] req_q, req_d, addr_q, addr_d;
  logic [AW-1:0] st_q, st_d, sz_q, sz_d;
  logic [AW-1:0] lo_st_q, lo_st_d, lo_sz_q, lo_sz_d;
  logic lo_q, lo_d;
  logic [AW-1:0] ins_st_q, ins_st_d, ins_sz_q, ins_sz_d;
  logic ins_q, ins_d;
  logic [SegW-1:0] car_q, car_d;
  logic [AW+8:0] sum_q, sum_d;
  logic [HW-1:0] hidx_q, hidx_d;
  logic [1:0] stat_q, stat_d;
  logic [12:0] gr_q, gr_d;
  logic [11:0] pay_q, pay_d;
  ffha_pkg::rsp_t out_q, out_d;
  logic ov_q, ov_d;

  logic seg_we;
  logic [SW-1:0] seg_wa, seg_ra;
  logic [SegW-1:0] seg_wd, seg_rd;
  logic hdr_we;
  logic [HW-1:0] hdr_wa, hdr_ra;
  logic [HdrW-1:0] hdr_wd, hdr_rd;

  ffha_ram #(.Width(SegW), .Depth(MAX_SEGMENTS)) u_seg (
    .clk_i, .we_i(seg_we), .waddr_i(seg_wa), .wdata_i(seg_wd),
    .raddr_i(seg_ra), .rdata_o(seg_rd)
  );
  ffha_ram #(.Width(HdrW), .Depth(HdrDepth)) u_hdr (
    .clk_i, .we_i(hdr_we), .waddr_i(hdr_wa), .wdata_i(hdr_wd),
    .raddr_i(hdr_ra), .rdata_o(hdr_rd)
  );

  logic [AW-1:0] rd_st, rd_sz;
  assign rd_st = seg_rd[SegW-1:AW];
  assign rd_sz = seg_rd[AW-1:0];

  // The segment memory is always read at pos_d so the data sits ready next cycle.
  assign seg_ra = pos_d[SW-1:0];
  assign hdr_ra = hidx_d;

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [AW-1:0] rest;
    logic [AW-1:0] hdr_off;
    state_d = state_q; clr_d = clr_q; cnt_d = cnt_q; pos_d = pos_q;
    live_d = live_q; ftot_d = ftot_q; cmd_d = cmd_q; req_d = req_q; addr_d = addr_q;
    st_d = st_q; sz_d = sz_q; lo_st_d = lo_st_q; lo_sz_d = lo_sz_q; lo_d = lo_q;
    ins_st_d = ins_st_q; ins_sz_d = ins_sz_q; ins_d = ins_q; car_d = car_q;
    sum_d = sum_q; hidx_d = hidx_q; stat_d = stat_q; gr_d = gr_q; pay_d = pay_q;
    out_d = out_q; ov_d = ov_q;
    seg_we = 1'b0; seg_wa = pos_q[SW-1:0]; seg_wd = car_q;
    hdr_we = 1'b0; hdr_wa = hidx_q; hdr_wd = '0;
    rest = sz_q - req_q;
    hdr_off = addr_q - Hdr;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLR: begin
        // Entry zero of the segment table starts out as the whole heap.
        seg_we = 1'b1; seg_wa = '0; seg_wd = {AW'(0), Init};
        hdr_we = 1'b1; hdr_wa = clr_q; hdr_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == HW'(HdrDepth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        pos_d = '0;
        if (in_valid_i && in_ready_o) begin
          cmd_d = in_data_i.command;
          req_d = ((AW'(in_data_i.req_size) + AW'(ALIGN_BYTES - 1)) >> AlShift) << AlShift;
          addr_d = AW'(in_data_i.block_addr);
          stat_d = ffha_pkg::ST_OK; gr_d = '0; pay_d = '0;
          hidx_d = HW'((AW'(in_data_i.block_addr) - Hdr) >> AlShift);
          if (in_data_i.command == ffha_pkg::CMD_ALLOC) begin
            if (in_data_i.req_size == '0) begin
              stat_d = ffha_pkg::ST_INVALID; state_d = S_OUT;
            end else begin
              state_d = S_ARD;
            end
          end else begin
            state_d = S_FHDR;
          end
        end
      end
      S_ARD: state_d = S_ACHK;  // first read in flight
      S_ACHK: begin
        if (pos_q >= cnt_q) begin
          stat_d = ffha_pkg::ST_NOFIT; state_d = S_OUT;
        end else if (rd_sz >= req_q) begin
          st_d = rd_st; sz_d = rd_sz;
          state_d = S_AHDR;
        end else begin
          pos_d = pos_q + 1'b1; state_d = S_ARD;
        end
      end
      S_AHDR: begin
        // Split check, then remove the segment by shifting the rest down.
        ins_d = rest > Split;
        ins_st_d = st_q + Hdr + req_q;
        ins_sz_d = rest - Hdr;
        gr_d = 13'(ins_d ? req_q : sz_q);
        pay_d = 12'(st_q + Hdr);
        hidx_d = HW'(st_q >> AlShift);
        if (live_q != 8'd255) live_d = live_q + 1'b1;
        hdr_we = 1'b1; hdr_wa = HW'(st_q >> AlShift); hdr_wd = {1'b1, ins_d ? req_q : sz_q};
        pos_d = pos_q + 1'b1;
        state_d = S_DEL;
      end
      S_DEL: begin
        // Data for pos_q arrived; write it one place down.
        if (pos_q >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          if (ins_q) begin
            st_d = ins_st_q; sz_d = ins_sz_q; pos_d = '0; state_d = S_FSCAN;
            lo_d = 1'b0; cmd_d = ffha_pkg::CMD_ALLOC;
          end else begin
            pos_d = '0; sum_d = '0;
            state_d = (cmd_q == ffha_pkg::CMD_FREE) ? S_HW : S_SUM;
          end
        end else begin
          seg_we = 1'b1; seg_wa = SW'(pos_q - 1'b1); seg_wd = seg_rd;
          pos_d = pos_q + 1'b1;
        end
      end
      S_FHDR: state_d = S_FHI;
      S_FHI: begin
        if (addr_q < Hdr || (hdr_off & AW'(ALIGN_BYTES - 1)) != '0 ||
            hdr_off >= AW'(HeapAligned) || !hdr_rd[HdrW-1]) begin
          stat_d = ffha_pkg::ST_INVALID; state_d = S_OUT;
        end else begin
          st_d = hdr_off; sz_d = hdr_rd[HdrW-2:0];
          lo_d = 1'b0; pos_d = '0; state_d = S_FSCAN;
        end
      end
      S_FSCAN: state_d = S_FCHK;
      S_FCHK: begin
        // Find the first segment whose start is not below st_q.
        if (pos_q < cnt_q && rd_st < st_q) begin
          lo_st_d = rd_st; lo_sz_d = rd_sz;
          lo_d = (rd_st + Hdr + rd_sz) == st_q;
          pos_d = pos_q + 1'b1; state_d = S_FSCAN;
        end else begin
          if (pos_q < cnt_q && (st_q + Hdr + sz_q) == rd_st) begin
            if (lo_q) begin
              seg_we = 1'b1; seg_wa = SW'(pos_q - 1'b1);
              seg_wd = {lo_st_q, lo_sz_q + Hdr + sz_q + Hdr + rd_sz};
              pos_d = pos_q + 1'b1; ins_d = 1'b0; state_d = S_DEL;
            end else begin
              seg_we = 1'b1; seg_wd = {st_q, sz_q + Hdr + rd_sz};
              state_d = S_HW;
            end
          end else if (lo_q) begin
            seg_we = 1'b1; seg_wa = SW'(pos_q - 1'b1);
            seg_wd = {lo_st_q, lo_sz_q + Hdr + sz_q};
            state_d = S_HW;
          end else if (cnt_q >= CW'(MAX_SEGMENTS)) begin
            if (cmd_q == ffha_pkg::CMD_FREE) stat_d = ffha_pkg::ST_INVALID;
            state_d = (cmd_q == ffha_pkg::CMD_FREE) ? S_OUT : S_HW;
          end else begin
            // Insert by rippling entries up from pos_q.
            car_d = {st_q, sz_q};
            cnt_d = cnt_q + 1'b1;
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        // seg_rd holds the old entry at pos_q (or junk past the end).
        seg_we = 1'b1; seg_wd = car_q;
        car_d = seg_rd;
        pos_d = pos_q + 1'b1;
        if (pos_q + 1'b1 >= cnt_q) state_d = S_HW;
      end
      S_HW: begin
        if (cmd_q == ffha_pkg::CMD_FREE) begin
          hdr_we = 1'b1; hdr_wd = {1'b0, hdr_rd[HdrW-2:0]};
          if (live_q != 8'd0) live_d = live_q - 1'b1;
        end
        pos_d = '0; sum_d = '0; state_d = S_SUM;
      end
      S_SUM: begin
        // The data read in this cycle belongs to pos_q.
        if (pos_q < cnt_q) sum_d = sum_q + (AW+9)'(rd_sz);
        if (pos_q + 1'b1 >= cnt_q) begin
          state_d = S_OUT;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_OUT: begin
        ftot_d = (stat_q == ffha_pkg::ST_OK) ? ((sum_q > (AW+9)'(8191)) ? 13'd8191 : 13'(sum_q))
                                               : ftot_q;
        out_d.status = stat_q;
        out_d.payload_addr = (stat_q == ffha_pkg::ST_OK) ? pay_q : '0;
        out_d.granted_size = (stat_q == ffha_pkg::ST_OK) ? gr_q : '0;
        out_d.live_blocks = live_q;
        out_d.free_bytes = ftot_d;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; cnt_q <= CW'(1); live_q <= '0;
      ftot_q <= 13'(Init); ov_q <= 1'b0; pos_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; cnt_q <= cnt_d; live_q <= live_d;
      ftot_q <= ftot_d; ov_q <= ov_d; pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; req_q <= req_d; addr_q <= addr_d; st_q <= st_d; sz_q <= sz_d;
    lo_st_q <= lo_st_d; lo_sz_q <= lo_sz_d; lo_q <= lo_d; ins_st_q <= ins_st_d;
    ins_sz_q <= ins_sz_d; ins_q <= ins_d; car_q <= car_d; sum_q <= sum_d;
    hidx_q <= hidx_d; stat_q <= stat_d; gr_q <= gr_d; pay_q <= pay_d; out_q <= out_d;
  end

endmodule
